// ----- hdl/page_frame_bitmap_allocator_unit_assert.svh -----
// Assertion macros for the page frame allocator
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pfa_pkg.sv -----
`timescale 1ns / 1ps
package pfa_pkg;
    localparam int MAX_PAGES = 65536;
    localparam int WORD_BITS = 32;
    localparam int NWORDS    = MAX_PAGES / WORD_BITS;
    localparam int WADDR_W   = $clog2(NWORDS);
    localparam int BIDX_W    = $clog2(WORD_BITS);
    localparam int PAGE_W    = WADDR_W + BIDX_W;
    localparam int CNT_W     = PAGE_W + 1;
    localparam logic [WADDR_W-1:0] HINT_RESET = WADDR_W'(8);
    localparam logic [31:0] LOW_LIMIT = 32'h0010_0000;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_PROTECTED = 2'd2,
        ST_RANGE_IGN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_TOTAL   = 3'd0,
        REG_KSTART  = 3'd1,
        REG_KEND    = 3'd2,
        REG_BBASE   = 3'd3,
        REG_BBYTES  = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_A_RD, S_A_WAIT, S_A_CHK,
        S_R_RD, S_R_WAIT, S_R_WR, S_OUT
    } fsm_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic a_issue;
        logic a_check;
        logic r_issue;
        logic r_write;
        logic decode;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        cmd_t cmd;
        logic early_done;   // free or ignored range already resolved
        logic a_last;       // alloc finishes this check
        logic r_last;       // this write ends the range
    } dp_stat_t;
endpackage

// ----- hdl/pfa_if.sv -----
`timescale 1ns / 1ps
interface pfa_req_if;
    import pfa_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] page_address;
    logic [63:0] region_base;
    logic [63:0] region_length;
    modport source (output valid, command, page_address, region_base, region_length,
                    input ready);
    modport sink (input valid, command, page_address, region_base, region_length,
                  output ready);
endinterface

interface pfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_address;
    modport source (output valid, status, granted_address, input ready);
    modport sink (input valid, status, granted_address, output ready);
endinterface

// ----- hdl/pfa_ram.sv -----
`timescale 1ns / 1ps
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/pfa_ctrl.sv -----
`timescale 1ns / 1ps
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:   if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (stat.early_done)            state_next = S_OUT;
                else if (stat.cmd == CMD_ALLOC) state_next = S_A_RD;
                else                            state_next = S_R_RD;
            end
            S_A_RD:   state_next = S_A_WAIT;
            S_A_WAIT: state_next = S_A_CHK;
            S_A_CHK:  state_next = stat.a_last ? S_OUT : S_A_RD;
            S_R_RD:   state_next = S_R_WAIT;
            S_R_WAIT: state_next = S_R_WR;
            S_R_WR:   state_next = stat.r_last ? S_OUT : S_R_RD;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:  cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE: cmd.decode  = 1'b1;
            S_A_RD:   cmd.a_issue = 1'b1;
            S_A_CHK:  cmd.a_check = 1'b1;
            S_R_RD:   cmd.r_issue = 1'b1;
            S_R_WR:   cmd.r_write = 1'b1;
            S_OUT:    out_valid   = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule

// ----- hdl/pfa_dp.sv -----
`timescale 1ns / 1ps
module pfa_dp
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  in_command,
    input  logic [31:0] in_page_address,
    input  logic [63:0] in_region_base,
    input  logic [63:0] in_region_length,
    input  logic [16:0] page_limit,
    input  logic [31:0] kernel_start,
    input  logic [31:0] kernel_end,
    input  logic [31:0] bitmap_base,
    input  logic [13:0] bmap_len,
    output logic [1:0]  status,
    output logic [31:0] granted_address
);
    logic [1:0]          cmd_reg;
    logic [31:0]         addr_reg;
    logic [63:0]         base_reg, len_reg;
    logic [WADDR_W-1:0]  hint_reg;
    logic [WADDR_W-1:0]  clr_reg;
    logic [WADDR_W-1:0]  aw_reg;        // word being scanned
    logic [CNT_W-1:0]    p_reg, last_reg; // range page cursor / end
    logic [1:0]          status_reg;
    logic [31:0]         gaddr_reg;

    logic                we;
    logic [WADDR_W-1:0]  waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    pfa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // managed page count, clamped
    logic [CNT_W-1:0] tot;
    assign tot = (page_limit > 17'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(page_limit);

    // word count rounded up
    logic [WADDR_W:0] nwords_used;
    assign nwords_used = (WADDR_W+1)'((tot + CNT_W'(WORD_BITS - 1)) >> BIDX_W);

    // alloc scan: lowest clear bit
    logic [BIDX_W-1:0] lz;
    logic              any_clear;
    always_comb
    begin
        lz = '0;
        any_clear = 1'b0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!rdata[i])
            begin
                lz = BIDX_W'(i);
                any_clear = 1'b1;
            end
        end
    end
    logic [CNT_W-1:0] a_page;
    assign a_page = {1'b0, aw_reg, lz};
    logic a_word_ok;
    assign a_word_ok = {1'b0, aw_reg} < nwords_used;

    // free protection checks
    logic prot;
    assign prot = (addr_reg < LOW_LIMIT)
               || (addr_reg >= kernel_start && addr_reg < kernel_end)
               || ({1'b0, addr_reg} >= {1'b0, bitmap_base}
                   && {1'b0, addr_reg} < ({1'b0, bitmap_base} + 33'(bmap_len)));
    logic [19:0] f_page;
    assign f_page = addr_reg[31:12];

    // range bounds
    logic [64:0] room, len_c, end_c;
    logic [20:0] last_pg;
    assign room   = 65'h1_0000_0000 - {1'b0, base_reg};
    assign len_c  = ({1'b0, len_reg} > room) ? room : {1'b0, len_reg};
    assign end_c  = {1'b0, base_reg} + len_c + 65'd4095;
    assign last_pg = end_c[32:12];

    logic [BIDX_W-1:0] r_bit;
    assign r_bit = p_reg[BIDX_W-1:0];

    always_comb
    begin
        we    = 1'b0;
        waddr = clr_reg;
        wdata = '1;
        raddr = aw_reg;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cmd.a_check && a_word_ok && any_clear && a_page < tot)
        begin
            we    = 1'b1;
            waddr = aw_reg;
            wdata = rdata | (WORD_BITS'(1) << lz);
        end
        else if (cmd.r_write)
        begin
            we    = 1'b1;
            waddr = p_reg[PAGE_W-1:BIDX_W];
            wdata = (cmd_reg == CMD_RESERVE) ? (rdata | (WORD_BITS'(1) << r_bit))
                                             : (rdata & ~(WORD_BITS'(1) << r_bit));
        end
        else if (cmd.decode && cmd_reg == CMD_FREE && !prot && {1'b0, f_page} < 21'(tot))
        begin
            we = 1'b0;
        end
        // page walks hold the word address through the read and the wait cycle
        if (cmd_reg != CMD_ALLOC)
        begin
            raddr = p_reg[PAGE_W-1:BIDX_W];
        end
    end

    logic [1:0] dec_status;
    logic       dec_early;

    // free is done as a one-page range write
    assign stat.clr_last   = (clr_reg == WADDR_W'(NWORDS - 1));
    assign stat.cmd        = cmd_t'(cmd_reg);
    assign stat.early_done = dec_early;
    assign stat.a_last     = !a_word_ok || any_clear || aw_reg == WADDR_W'(NWORDS - 1);
    assign stat.r_last     = (p_reg + CNT_W'(1)) >= last_reg;

    always_comb
    begin
        dec_status = ST_DONE;
        dec_early  = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_FREE:
            begin
                if (prot)
                begin
                    dec_status = ST_PROTECTED;
                    dec_early  = 1'b1;
                end
                else if (!({1'b0, f_page} < 21'(tot)))
                begin
                    dec_early = 1'b1;
                end
            end
            CMD_RESERVE, CMD_RELEASE:
            begin
                if (base_reg[63:32] != 32'd0 || len_c == 65'd0)
                begin
                    dec_status = ST_RANGE_IGN;
                    dec_early  = 1'b1;
                end
                else if ({1'b0, base_reg[31:12]} >= (last_pg < 21'(tot) ? last_pg : 21'(tot)))
                begin
                    dec_early = 1'b1;
                end
            end
            default: dec_early = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            hint_reg <= HINT_RESET;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + WADDR_W'(1);
            end
            if (cmd.decode && cmd_reg == CMD_FREE && !prot
                && 20'(f_page[19:BIDX_W]) < 20'(hint_reg))
            begin
                hint_reg <= WADDR_W'(f_page[19:BIDX_W]);
            end
            if (cmd.a_check && a_word_ok && any_clear && a_page < tot)
            begin
                hint_reg <= aw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= in_command;
            addr_reg <= in_page_address;
            base_reg <= in_region_base;
            len_reg  <= in_region_length;
        end
        if (cmd.decode)
        begin
            aw_reg     <= hint_reg;
            status_reg <= dec_status;
            gaddr_reg  <= '0;
            if (cmd_reg == CMD_FREE)
            begin
                p_reg    <= CNT_W'(f_page);
                last_reg <= CNT_W'(f_page) + CNT_W'(1);
            end
            else
            begin
                p_reg    <= CNT_W'(base_reg[31:12]);
                last_reg <= (last_pg < 21'(tot)) ? CNT_W'(last_pg) : tot;
            end
        end
        if (cmd.a_check)
        begin
            if (!a_word_ok || (any_clear && !(a_page < tot)))
            begin
                status_reg <= ST_NO_FREE;
            end
            else if (any_clear)
            begin
                gaddr_reg <= 32'({a_page[PAGE_W-1:0], 12'd0});
            end
            else if (aw_reg == WADDR_W'(NWORDS - 1))
            begin
                status_reg <= ST_NO_FREE;
            end
            aw_reg <= aw_reg + WADDR_W'(1);
        end
        if (cmd.r_write)
        begin
            p_reg <= p_reg + CNT_W'(1);
        end
    end

    assign status          = status_reg;
    assign granted_address = gaddr_reg;
endmodule

// ----- hdl/page_frame_bitmap_allocator_unit.sv -----
`timescale 1ns / 1ps
// Channel   Role   Transfer carries
// req       sink   command, page_address, region_base, region_length
// rsp       source status, granted_address
// apb       slave  five configuration registers at 4*i
//
// Allocate: accept, decode, a read, wait and check per bitmap word scanned from the hint, output.
// Free: accept, decode and output, plus a read, wait and write when the page is written back (read-modify-write).
// Range: a read, wait and write per page of the range; an ignored or empty range goes from decode to output.
// After reset a clearing pass sets every bitmap word to all used.
// A result waits in its register until taken; no new transfer meanwhile.
module page_frame_bitmap_allocator_unit
    import pfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pfa_req_if.sink     req,
    pfa_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [16:0] total_reg;
    logic [31:0] kstart_reg, kend_reg, bbase_reg;
    logic [13:0] bbytes_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            kstart_reg <= '0;
            kend_reg   <= '0;
            bbase_reg  <= '0;
            bbytes_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_TOTAL:  total_reg  <= pwdata[16:0];
                REG_KSTART: kstart_reg <= pwdata;
                REG_KEND:   kend_reg   <= pwdata;
                REG_BBASE:  bbase_reg  <= pwdata;
                REG_BBYTES: bbytes_reg <= pwdata[13:0];
                default:    total_reg  <= total_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_TOTAL:  prdata = {15'd0, total_reg};
            REG_KSTART: prdata = kstart_reg;
            REG_KEND:   prdata = kend_reg;
            REG_BBASE:  prdata = bbase_reg;
            REG_BBYTES: prdata = {18'd0, bbytes_reg};
            default:    prdata = '0;
        endcase
    end

    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    pfa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(dstat), .cmd(dcmd)
    );

    pfa_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .stat(dstat),
        .in_command(req.command), .in_page_address(req.page_address),
        .in_region_base(req.region_base), .in_region_length(req.region_length),
        .page_limit(total_reg), .kernel_start(kstart_reg), .kernel_end(kend_reg),
        .bitmap_base(bbase_reg), .bmap_len(bbytes_reg),
        .status(rsp.status), .granted_address(rsp.granted_address)
    );
endmodule

// ----- hdl/pfa_checker.sv -----
`timescale 1ns / 1ps
`include "page_frame_bitmap_allocator_unit_assert.svh"
module pfa_checker
    import pfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_granted_address
);
    `PFA_ASSERT_IMP(a_no_overlap, clk, rst_n, rsp_valid, !req_ready, "accept while result waits")
    `PFA_ASSERT_NXT(a_busy_after, clk, rst_n, req_valid && req_ready, !req_ready, "ready after accept")
    `PFA_ASSERT_IMP(a_addr_zero, clk, rst_n, rsp_valid && rsp_status != ST_DONE, rsp_granted_address == 32'd0, "address without grant")
    `PFA_ASSERT_IMP(a_page_align, clk, rst_n, rsp_valid, rsp_granted_address[11:0] == 12'd0, "unaligned grant")
endmodule

bind page_frame_bitmap_allocator_unit pfa_checker u_pfa_checker (
    .clk(clk), .rst_n(rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_granted_address(rsp.granted_address)
);
